// ----- rtl/sbs_pkg.sv -----
// ----------------------------------------------------------------------------
// sbs_pkg: shared types and constants of the sorted table search
// word codes, field widths and the control structs between top and engine
// ----------------------------------------------------------------------------
package sbs_pkg;

	localparam int DATA_W          = 32;
	localparam int IDX_W           = 10;
	localparam int CNT_W           = 11;
	localparam int WIDE_W          = 17;
	localparam int TABLE_DEPTH_DEF = 1024;

	typedef enum logic {
		CMD_WRITE  = 1'b0,
		CMD_SEARCH = 1'b1
	} cmd_t;

	// request from the front end to the search engine
	typedef struct packed {
		logic                     start;
		logic signed [DATA_W-1:0] key;
		logic [CNT_W-1:0]         count;
		logic                     out_free;
	} req_t;

	// status and result from the search engine
	typedef struct packed {
		logic             busy;
		logic             done;
		logic             found;
		logic [IDX_W-1:0] position;
	} rsp_t;

endpackage

// ----- rtl/sbs_table.sv -----
// ----------------------------------------------------------------------------
// sbs_table: entry memory of the sorted table search
// one write port and one read port, read data registered
// ----------------------------------------------------------------------------
module sbs_table #(
	parameter int TABLE_DEPTH = sbs_pkg::TABLE_DEPTH_DEF,
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [AW-1:0]                    waddr,
	input  logic signed [sbs_pkg::DATA_W-1:0] wdata,
	input  logic                             re,
	input  logic [AW-1:0]                    raddr,
	output logic signed [sbs_pkg::DATA_W-1:0] rdata
);
	import sbs_pkg::*;

	logic signed [DATA_W-1:0] mem_q [TABLE_DEPTH];
	logic signed [DATA_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/sbs_engine.sv -----
// ----------------------------------------------------------------------------
// sbs_engine: binary search sequencer
// one midpoint adder and one signed less-than compare, reused for every probe
// ----------------------------------------------------------------------------
module sbs_engine #(
	parameter int TABLE_DEPTH = sbs_pkg::TABLE_DEPTH_DEF,
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sbs_pkg::req_t                     req,
	output sbs_pkg::rsp_t                     rsp,
	output logic                              rd_en,
	output logic [AW-1:0]                     rd_addr,
	input  logic signed [sbs_pkg::DATA_W-1:0] rd_data
);
	import sbs_pkg::*;

	localparam logic [WIDE_W-1:0] DEPTH_V = WIDE_W'(TABLE_DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_PROBE = 3'b010,
		ST_DONE  = 3'b100
	} state_t;

	state_t                   state_q, state_d;
	logic [CNT_W-1:0]         low_q, low_d;
	logic [CNT_W-1:0]         end_q, end_d;
	logic [CNT_W-1:0]         mid_q, mid_d;
	logic signed [DATA_W-1:0] key_q;
	logic                     found_q, found_d;
	logic [IDX_W-1:0]         pos_q, pos_d;

	logic [WIDE_W-1:0] cnt_wide;
	logic [CNT_W-1:0]  eff_cnt;
	logic              probe_lt;
	logic [CNT_W-1:0]  low_nx;
	logic [CNT_W-1:0]  end_nx;
	logic [CNT_W:0]    mid_sum;
	logic [CNT_W-1:0]  next_mid;
	logic [WIDE_W-1:0] mid_wide;
	logic              range_open;

	// count clamped to the table depth
	assign cnt_wide = WIDE_W'(req.count);
	assign eff_cnt  = (cnt_wide > DEPTH_V) ? DEPTH_V[CNT_W-1:0] : req.count;

	// shared signed compare of the probed entry against the key
	assign probe_lt = (rd_data < key_q);

	// next search range: fresh on a new word, narrowed after each compare
	always_comb begin
		low_nx = low_q;
		end_nx = end_q;
		case (state_q)
			ST_IDLE: begin
				low_nx = '0;
				end_nx = eff_cnt;
			end
			ST_PROBE: begin
				if (probe_lt) begin
					low_nx = mid_q + CNT_W'(1);
				end else begin
					end_nx = mid_q;
				end
			end
			default: begin
			end
		endcase
	end

	// shared midpoint unit: floor((low + end - 1) / 2), end exclusive
	assign mid_sum    = {1'b0, low_nx} + {1'b0, end_nx} - {{CNT_W{1'b0}}, 1'b1};
	assign next_mid   = mid_sum[CNT_W:1];
	assign mid_wide   = WIDE_W'(next_mid);
	assign range_open = (low_nx < end_nx);

	// sequencer: start a search, narrow the range on each compare, stop on a hit or an empty range
	always_comb begin
		state_d = state_q;
		low_d   = low_nx;
		end_d   = end_nx;
		mid_d   = mid_q;
		found_d = found_q;
		pos_d   = pos_q;
		rd_en   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req.start) begin
					found_d = 1'b0;
					pos_d   = '0;
					if (range_open) begin
						rd_en   = 1'b1;
						mid_d   = next_mid;
						state_d = ST_PROBE;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_PROBE: begin
				if (rd_data == key_q) begin
					found_d = 1'b1;
					pos_d   = mid_q[IDX_W-1:0];
					state_d = ST_DONE;
				end else if (range_open) begin
					rd_en = 1'b1;
					mid_d = next_mid;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (req.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign rd_addr = mid_wide[AW-1:0];

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// search range and result
	always_ff @(posedge clk) begin
		low_q   <= low_d;
		end_q   <= end_d;
		mid_q   <= mid_d;
		found_q <= found_d;
		pos_q   <= pos_d;
		if (req.start && state_q == ST_IDLE) begin
			key_q <= req.key;
		end
	end

	assign rsp.busy     = (state_q != ST_IDLE);
	assign rsp.done     = (state_q == ST_DONE);
	assign rsp.found    = found_q;
	assign rsp.position = pos_q;

endmodule

// ----- rtl/sorted_table_binary_search.sv -----
// ----------------------------------------------------------------------------
// sorted_table_binary_search: table of signed entries with binary search
// write word: written on acceptance, in_ready stays high, no result
// search word: at most log2(TABLE_DEPTH)+1 probes, result held in the engine
// until the output register is free, next word taken once the result is
// registered
// the probe loop is bound by the single registered memory read per probe
// reset clears control and active_count; table contents are undefined
// ----------------------------------------------------------------------------
module sorted_table_binary_search #(
	parameter int TABLE_DEPTH = sbs_pkg::TABLE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [sbs_pkg::CNT_W-1:0]         cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              cmd,
	input  logic [sbs_pkg::IDX_W-1:0]         entry_index,
	input  logic signed [sbs_pkg::DATA_W-1:0] entry_value,
	input  logic signed [sbs_pkg::DATA_W-1:0] search_key,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              found,
	output logic [sbs_pkg::IDX_W-1:0]         position
);
	import sbs_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [WIDE_W-1:0] DEPTH_V = WIDE_W'(TABLE_DEPTH);

	logic [CNT_W-1:0]         cnt_q;
	logic                     out_valid_q;
	logic                     found_q;
	logic [IDX_W-1:0]         position_q;
	logic                     accept;
	logic [WIDE_W-1:0]        idx_wide;
	logic                     wr_en;
	logic                     rd_en;
	logic [AW-1:0]            rd_addr;
	logic signed [DATA_W-1:0] rd_data;
	req_t                     req;
	rsp_t                     rsp;

	// active count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cfg_we) begin
			cnt_q <= cfg_wdata;
		end
	end

	// input word decode
	assign in_ready = !rsp.busy;
	assign accept   = in_valid && in_ready;
	assign idx_wide = WIDE_W'(entry_index);
	assign wr_en    = accept && (cmd == CMD_WRITE) && (idx_wide < DEPTH_V);

	assign req.start    = accept && (cmd == CMD_SEARCH);
	assign req.key      = search_key;
	assign req.count    = cnt_q;
	assign req.out_free = !out_valid_q || out_ready;

	sbs_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (idx_wide[AW-1:0]),
		.wdata (entry_value),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	sbs_engine #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rsp.done && req.out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp.done && req.out_free) begin
			found_q    <= rsp.found;
			position_q <= rsp.position;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign position  = position_q;

	// a miss always reports position zero
	a_miss_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done && !rsp.found |-> rsp.position == '0)
		else $error("miss with non-zero position");

	// a finished search with room downstream shows up on the output
	a_done_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done && req.out_free |=> out_valid_q)
		else $error("finished search not presented");

	// a hit lies inside the active range
	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done && rsp.found |-> {1'b0, rsp.position} < cnt_q)
		else $error("hit outside active range");

	// no new word is taken while a search is running
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		$past(req.start) |-> !in_ready || $past(cnt_q) == '0)
		else $error("word accepted during search");

endmodule
